[hw/rtl/ptgc_pkg.sv]
`default_nettype none

package ptgc_pkg;

   localparam int POINT_W = 32;
   localparam int EDGE_W  = 32;
   localparam int SIZE_W  = 31;
   localparam int COUNT_W = 13;
   localparam int INDEX_W = 24;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_GRID_LEFT    = 3'd0,
      CSR_GRID_RIGHT   = 3'd1,
      CSR_GRID_BOTTOM  = 3'd2,
      CSR_GRID_TOP     = 3'd3,
      CSR_CELL_WIDTH   = 3'd4,
      CSR_CELL_HEIGHT  = 3'd5,
      CSR_COLUMN_COUNT = 3'd6,
      CSR_ROW_COUNT    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] cell_index;
      logic               outside_grid;
   } rsp_payload_type;

endpackage

`default_nettype wire

[hw/rtl/ptgc_front.sv]
`default_nettype none

module ptgc_front #(
   parameter int CW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_vld,
   input  logic [ptgc_pkg::POINT_W-1:0]  point_x,
   input  logic [ptgc_pkg::POINT_W-1:0]  point_y,
   input  logic [ptgc_pkg::EDGE_W-1:0]   grid_left,
   input  logic [ptgc_pkg::EDGE_W-1:0]   grid_right,
   input  logic [ptgc_pkg::EDGE_W-1:0]   grid_bottom,
   input  logic [ptgc_pkg::EDGE_W-1:0]   grid_top,
   output logic                          out_vld,
   output logic                          out_outside,
   output logic [CW-1:0]                 out_off_x,
   output logic [CW-1:0]                 out_off_y
);

   logic signed [CW-1:0] px, py, left, right, bottom, top;
   logic                 outside_in;
   logic [CW-1:0]        off_x_in, off_y_in;

   logic                 vld_ff;
   logic                 outside_ff;
   logic [CW-1:0]        off_x_ff, off_y_ff;

   // register bits reinterpreted as coord_width two's complement
   always_comb begin
      px     = $signed(CW'(point_x));
      py     = $signed(CW'(point_y));
      left   = $signed(CW'(grid_left));
      right  = $signed(CW'(grid_right));
      bottom = $signed(CW'(grid_bottom));
      top    = $signed(CW'(grid_top));
      outside_in = (px < left) || (px > right) || (py < bottom) || (py > top);
      off_x_in = CW'(px - left);
      off_y_in = CW'(top - py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_vld;
      end
      if (advance) begin
         outside_ff <= outside_in;
         off_x_ff   <= off_x_in;
         off_y_ff   <= off_y_in;
      end
   end

   assign out_vld     = vld_ff;
   assign out_outside = outside_ff;
   assign out_off_x   = off_x_ff;
   assign out_off_y   = off_y_ff;

endmodule

`default_nettype wire

[hw/rtl/ptgc_div_cell.sv]
`default_nettype none

module ptgc_div_cell #(
   parameter int CW    = 32,
   parameter int QW    = 12,
   parameter int SHIFT = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_vld,
   input  logic                         in_outside,
   input  logic [CW-1:0]                in_rem_x,
   input  logic [CW-1:0]                in_rem_y,
   input  logic [QW:0]                  in_quo_x,
   input  logic [QW:0]                  in_quo_y,
   input  logic [ptgc_pkg::SIZE_W-1:0]  size_x,
   input  logic [ptgc_pkg::SIZE_W-1:0]  size_y,
   output logic                         out_vld,
   output logic                         out_outside,
   output logic [CW-1:0]                out_rem_x,
   output logic [CW-1:0]                out_rem_y,
   output logic [QW:0]                  out_quo_x,
   output logic [QW:0]                  out_quo_y
);

   localparam int DW = (CW > ptgc_pkg::SIZE_W) ? CW : ptgc_pkg::SIZE_W;
   localparam int TW = ptgc_pkg::SIZE_W + SHIFT;

   logic [DW-1:0] hi_x, hi_y;
   logic          fit_x, fit_y;
   logic [TW-1:0] trial_x, trial_y;
   logic [CW-1:0] rem_x_in, rem_y_in;
   logic [QW:0]   quo_x_in, quo_y_in;

   logic          vld_ff;
   logic          outside_ff;
   logic [CW-1:0] rem_x_ff, rem_y_ff;
   logic [QW:0]   quo_x_ff, quo_y_ff;

   // one restoring step: does size << shift still fit in the remainder
   always_comb begin
      hi_x    = DW'(in_rem_x >> SHIFT);
      hi_y    = DW'(in_rem_y >> SHIFT);
      fit_x   = hi_x >= DW'(size_x);
      fit_y   = hi_y >= DW'(size_y);
      trial_x = TW'(size_x) << SHIFT;
      trial_y = TW'(size_y) << SHIFT;
      rem_x_in = fit_x ? (in_rem_x - CW'(trial_x)) : in_rem_x;
      rem_y_in = fit_y ? (in_rem_y - CW'(trial_y)) : in_rem_y;
      quo_x_in = in_quo_x;
      quo_y_in = in_quo_y;
      quo_x_in[SHIFT] = fit_x;
      quo_y_in[SHIFT] = fit_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_vld;
      end
      if (advance) begin
         outside_ff <= in_outside;
         rem_x_ff   <= rem_x_in;
         rem_y_ff   <= rem_y_in;
         quo_x_ff   <= quo_x_in;
         quo_y_ff   <= quo_y_in;
      end
   end

   assign out_vld     = vld_ff;
   assign out_outside = outside_ff;
   assign out_rem_x   = rem_x_ff;
   assign out_rem_y   = rem_y_ff;
   assign out_quo_x   = quo_x_ff;
   assign out_quo_y   = quo_y_ff;

endmodule

`default_nettype wire

[hw/rtl/ptgc_index.sv]
`default_nettype none

module ptgc_index #(
   parameter int QW  = 12,
   parameter int CXW = 13,
   parameter int CYW = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance_a,
   input  logic                          advance_b,
   input  logic                          in_vld,
   input  logic                          in_outside,
   input  logic [QW:0]                   in_quo_x,
   input  logic [QW:0]                   in_quo_y,
   input  logic [CXW-1:0]                cols,
   input  logic [CYW-1:0]                rows,
   output logic                          vld_a,
   output logic                          vld_b,
   output logic [ptgc_pkg::INDEX_W-1:0]  out_index,
   output logic                          out_outside
);

   localparam int PW = QW + CXW;
   localparam int SW = (PW > ptgc_pkg::INDEX_W) ? PW : ptgc_pkg::INDEX_W;

   logic [CXW-1:0] last_col;
   logic [CYW-1:0] last_row;
   logic [QW-1:0]  col_in, row_in;
   logic [SW-1:0]  sum_in;
   logic [ptgc_pkg::INDEX_W-1:0] index_in;

   logic           vld_a_ff, vld_b_ff;
   logic           outside_a_ff, outside_b_ff;
   logic [QW-1:0]  col_a_ff, row_a_ff;
   logic [ptgc_pkg::INDEX_W-1:0] index_b_ff;

   // saturate to the last column and row
   always_comb begin
      last_col = cols - CXW'(1);
      last_row = rows - CYW'(1);
      col_in = (in_quo_x > last_col) ? QW'(last_col) : QW'(in_quo_x);
      row_in = (in_quo_y > last_row) ? QW'(last_row) : QW'(in_quo_y);
   end

   always_comb begin
      sum_in   = SW'(row_a_ff) * SW'(cols) + SW'(col_a_ff);
      index_in = outside_a_ff ? '0 : sum_in[ptgc_pkg::INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (advance_a) begin
            vld_a_ff <= in_vld;
         end
         if (advance_b) begin
            vld_b_ff <= vld_a_ff;
         end
      end
      if (advance_a) begin
         outside_a_ff <= in_outside;
         col_a_ff     <= col_in;
         row_a_ff     <= row_in;
      end
      if (advance_b) begin
         outside_b_ff <= outside_a_ff;
         index_b_ff   <= index_in;
      end
   end

   assign vld_a       = vld_a_ff;
   assign vld_b       = vld_b_ff;
   assign out_index   = index_b_ff;
   assign out_outside = outside_b_ff;

endmodule

`default_nettype wire

[hw/rtl/point_to_grid_cell_index.sv]
// Point to raster cell index.
// req channel: one point (point_x, point_y) per transfer, valid/stall handshake.
// rsp channel: one result per point, cell_index (row-major, rows counted down
// from grid_top) and outside_grid; cell_index is 0 when the point is outside.
// csr port: write-only, csr_wr_en with csr_index and csr_data; write only while
// no point is in flight.
// Order: an accepted point passes the front register, then each division
// cell, the saturate stage and the multiply-add output register.
// Throughput: one point per cycle while rsp_stall is low. The division runs
// through a row of clog2(max(MAX_COLUMNS, MAX_ROWS)) + 1 cells, one quotient
// bit per cell for both axes, followed by a saturate stage and a multiply-add
// output register. Each stage advances when it is empty or the next one
// advances, so bubbles fill even while rsp_stall is high; req_stall rises
// only once every stage holds a point and the output is stalled.
// Reset clears all pipeline valids and loads the register defaults
// (edges 0, cell size 1, counts 1).
`default_nettype none

module point_to_grid_cell_index #(
   parameter int COORD_WIDTH = 32,
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS    = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ptgc_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ptgc_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_wr_en,
   input  ptgc_pkg::csr_index_type          csr_index,
   input  logic [ptgc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int MAXQ = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int QW  = $clog2(MAXQ);
   localparam int NC  = QW + 1;
   localparam int CXW = $clog2(MAX_COLUMNS + 1);
   localparam int CYW = $clog2(MAX_ROWS + 1);
   localparam int NS  = NC + 3;

   logic [ptgc_pkg::EDGE_W-1:0]  grid_left_ff, grid_right_ff, grid_bottom_ff, grid_top_ff;
   logic [ptgc_pkg::SIZE_W-1:0]  cell_width_ff, cell_height_ff;
   logic [ptgc_pkg::COUNT_W-1:0] column_count_ff, row_count_ff;

   logic [ptgc_pkg::SIZE_W-1:0]  size_x_in, size_y_in, size_x_ff, size_y_ff;
   logic [CXW-1:0]               cols_in, cols_ff;
   logic [CYW-1:0]               rows_in, rows_ff;

   logic [NS-1:0] vld;
   logic [NS-1:0] en;
   logic [NC:0]   outside;
   logic [CW-1:0] rem_x [0:NC-1];
   logic [CW-1:0] rem_y [0:NC-1];
   logic [QW:0]   quo_x [0:NC];
   logic [QW:0]   quo_y [0:NC];

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_left_ff    <= '0;
         grid_right_ff   <= '0;
         grid_bottom_ff  <= '0;
         grid_top_ff     <= '0;
         cell_width_ff   <= ptgc_pkg::SIZE_W'(1);
         cell_height_ff  <= ptgc_pkg::SIZE_W'(1);
         column_count_ff <= ptgc_pkg::COUNT_W'(1);
         row_count_ff    <= ptgc_pkg::COUNT_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            ptgc_pkg::CSR_GRID_LEFT: begin
               grid_left_ff <= csr_data[ptgc_pkg::EDGE_W-1:0];
            end
            ptgc_pkg::CSR_GRID_RIGHT: begin
               grid_right_ff <= csr_data[ptgc_pkg::EDGE_W-1:0];
            end
            ptgc_pkg::CSR_GRID_BOTTOM: begin
               grid_bottom_ff <= csr_data[ptgc_pkg::EDGE_W-1:0];
            end
            ptgc_pkg::CSR_GRID_TOP: begin
               grid_top_ff <= csr_data[ptgc_pkg::EDGE_W-1:0];
            end
            ptgc_pkg::CSR_CELL_WIDTH: begin
               cell_width_ff <= csr_data[ptgc_pkg::SIZE_W-1:0];
            end
            ptgc_pkg::CSR_CELL_HEIGHT: begin
               cell_height_ff <= csr_data[ptgc_pkg::SIZE_W-1:0];
            end
            ptgc_pkg::CSR_COLUMN_COUNT: begin
               column_count_ff <= csr_data[ptgc_pkg::COUNT_W-1:0];
            end
            ptgc_pkg::CSR_ROW_COUNT: begin
               row_count_ff <= csr_data[ptgc_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // zero size reads as one, counts clamped to 1..max
   always_comb begin
      size_x_in = (cell_width_ff == '0) ? ptgc_pkg::SIZE_W'(1) : cell_width_ff;
      size_y_in = (cell_height_ff == '0) ? ptgc_pkg::SIZE_W'(1) : cell_height_ff;
      if (column_count_ff == '0) begin
         cols_in = CXW'(1);
      end else if (column_count_ff > MAX_COLUMNS) begin
         cols_in = CXW'(MAX_COLUMNS);
      end else begin
         cols_in = CXW'(column_count_ff);
      end
      if (row_count_ff == '0) begin
         rows_in = CYW'(1);
      end else if (row_count_ff > MAX_ROWS) begin
         rows_in = CYW'(MAX_ROWS);
      end else begin
         rows_in = CYW'(row_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= ptgc_pkg::SIZE_W'(1);
         size_y_ff <= ptgc_pkg::SIZE_W'(1);
         cols_ff   <= CXW'(1);
         rows_ff   <= CYW'(1);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         cols_ff   <= cols_in;
         rows_ff   <= rows_in;
      end
   end

   // a stage loads when empty or when its successor loads
   assign en[NS-1] = !vld[NS-1] || !rsp_stall;
   generate
      for (genvar s = 0; s < NS - 1; s++) begin : g_adv
         assign en[s] = !vld[s] || en[s+1];
      end
   endgenerate

   assign req_stall = !en[0];

   ptgc_front #(
      .CW (CW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (en[0]),
      .in_vld      (req_valid),
      .point_x     (req_payload.point_x),
      .point_y     (req_payload.point_y),
      .grid_left   (grid_left_ff),
      .grid_right  (grid_right_ff),
      .grid_bottom (grid_bottom_ff),
      .grid_top    (grid_top_ff),
      .out_vld     (vld[0]),
      .out_outside (outside[0]),
      .out_off_x   (rem_x[0]),
      .out_off_y   (rem_y[0])
   );

   assign quo_x[0] = '0;
   assign quo_y[0] = '0;

   generate
      for (genvar k = 1; k <= NC; k++) begin : g_cell
         if (k < NC) begin : g_mid
            ptgc_div_cell #(
               .CW    (CW),
               .QW    (QW),
               .SHIFT (NC - k)
            ) u_cell (
               .clock       (clock),
               .reset       (reset),
               .advance     (en[k]),
               .in_vld      (vld[k-1]),
               .in_outside  (outside[k-1]),
               .in_rem_x    (rem_x[k-1]),
               .in_rem_y    (rem_y[k-1]),
               .in_quo_x    (quo_x[k-1]),
               .in_quo_y    (quo_y[k-1]),
               .size_x      (size_x_ff),
               .size_y      (size_y_ff),
               .out_vld     (vld[k]),
               .out_outside (outside[k]),
               .out_rem_x   (rem_x[k]),
               .out_rem_y   (rem_y[k]),
               .out_quo_x   (quo_x[k]),
               .out_quo_y   (quo_y[k])
            );
         end else begin : g_last
            ptgc_div_cell #(
               .CW    (CW),
               .QW    (QW),
               .SHIFT (0)
            ) u_cell (
               .clock       (clock),
               .reset       (reset),
               .advance     (en[k]),
               .in_vld      (vld[k-1]),
               .in_outside  (outside[k-1]),
               .in_rem_x    (rem_x[k-1]),
               .in_rem_y    (rem_y[k-1]),
               .in_quo_x    (quo_x[k-1]),
               .in_quo_y    (quo_y[k-1]),
               .size_x      (size_x_ff),
               .size_y      (size_y_ff),
               .out_vld     (vld[k]),
               .out_outside (outside[k]),
               .out_rem_x   (),
               .out_rem_y   (),
               .out_quo_x   (quo_x[k]),
               .out_quo_y   (quo_y[k])
            );
         end
      end
   endgenerate

   ptgc_index #(
      .QW  (QW),
      .CXW (CXW),
      .CYW (CYW)
   ) u_index (
      .clock       (clock),
      .reset       (reset),
      .advance_a   (en[NC+1]),
      .advance_b   (en[NC+2]),
      .in_vld      (vld[NC]),
      .in_outside  (outside[NC]),
      .in_quo_x    (quo_x[NC]),
      .in_quo_y    (quo_y[NC]),
      .cols        (cols_ff),
      .rows        (rows_ff),
      .vld_a       (vld[NC+1]),
      .vld_b       (vld[NC+2]),
      .out_index   (rsp_payload.cell_index),
      .out_outside (rsp_payload.outside_grid)
   );

   assign rsp_valid = vld[NS-1];

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.outside_grid |-> rsp_payload.cell_index == '0)
      else $error("outside point with nonzero cell index");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output register is empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_full_pipe: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && vld[0])
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
